// ===== hw/rtl/pow2_class_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power-of-two class block allocator
// Concurrent checks that vanish when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef POW2_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define POW2_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define P2A_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define P2A_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define P2A_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define P2A_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/p2alloc_pkg.sv =====
// ----------------------------------------------------------------------------
// p2alloc_pkg
// Shared constants, field widths and codes of the block allocator.
// ----------------------------------------------------------------------------
package p2alloc_pkg;

   // default configuration
   localparam int ARENA_LOG_DEF    = 16;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int NUM_CLASSES_DEF  = 32;

   // fixed field widths
   localparam int REQ_BYTES_W   = 32;
   localparam int OFFSET_W      = 16;
   localparam int BLOCK_BYTES_W = 17;
   localparam int SPLITS_W      = 32;
   localparam int TAG_W         = 5;

   // default memory shape: one link word per 32-byte slot
   localparam int RAM_WIDTH_DEF = OFFSET_W + 1;
   localparam int RAM_DEPTH_DEF = 1 << (ARENA_LOG_DEF - 5);

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic {
      STAT_DONE = 1'b0,
      STAT_FAIL = 1'b1
   } status_type;

endpackage

// ===== hw/rtl/p2alloc_req_if.sv =====
// ----------------------------------------------------------------------------
// p2alloc_req_if
// Request channel: allocate or free items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface p2alloc_req_if
   import p2alloc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   action_type             action;
   logic [REQ_BYTES_W-1:0] request_bytes;
   logic [OFFSET_W-1:0]    release_offset;
   logic                   release_present;

   modport source (
      output valid, action, request_bytes, release_offset, release_present,
      input  ready
   );

   modport sink (
      input  valid, action, request_bytes, release_offset, release_present,
      output ready
   );
endinterface

// ===== hw/rtl/p2alloc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// p2alloc_rsp_if
// Response channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface p2alloc_rsp_if
   import p2alloc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [OFFSET_W-1:0]      user_offset;
   logic [BLOCK_BYTES_W-1:0] block_bytes;
   logic [SPLITS_W-1:0]      splits_total;

   modport source (
      output valid, status, user_offset, block_bytes, splits_total,
      input  ready
   );

   modport sink (
      input  valid, status, user_offset, block_bytes, splits_total,
      output ready
   );
endinterface

// ===== hw/rtl/p2alloc_ram.sv =====
// ----------------------------------------------------------------------------
// p2alloc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module p2alloc_ram
   import p2alloc_pkg::*;
#(
   parameter int WIDTH = RAM_WIDTH_DEF,
   parameter int DEPTH = RAM_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pow2_class_block_allocator.sv =====
// ----------------------------------------------------------------------------
// pow2_class_block_allocator
// Power-of-two segregated free-list allocator with split-on-demand.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response per
// request. A null free goes straight to the response, a free reads the class
// tag of its slot and pushes the block, and an allocation finds a class, pops
// its head with its link and makes k halvings (at most ARENA_LOG minus the
// smallest class, 11 with the default 64 KiB arena) before tagging the block.
// Each halving writes one link word and one class tag through the single
// write port of each slot memory; the popped head's link word comes through
// the registered read of the link memory. A finished response sits in an
// output register, so the next request transfer is taken while it waits.
// Class heads live in flops; links and class tags live in two slot-indexed
// RAMs. There is no clearing pass: slot 0 reads its reset contents until written.
// ----------------------------------------------------------------------------
`include "pow2_class_block_allocator_assert.svh"

module pow2_class_block_allocator
   import p2alloc_pkg::*;
#(
   parameter int ARENA_LOG    = ARENA_LOG_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int NUM_CLASSES  = NUM_CLASSES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   p2alloc_req_if.sink   req_chan,
   p2alloc_rsp_if.source rsp_chan
);

   // smallest block ever handed out: 2^SLOT_LOG bytes
   localparam int SLOT_LOG   = (HEADER_BYTES >= 16) ? 5 : 4;
   localparam int AW         = ARENA_LOG;
   localparam int SLOT_W     = ARENA_LOG - SLOT_LOG;
   localparam int SLOT_COUNT = 1 << SLOT_W;
   localparam int CLS_W      = $clog2(NUM_CLASSES);
   localparam int LINK_W     = AW + 1;
   localparam int NEED_W     = REQ_BYTES_W + 1;
   localparam int LEN_W      = $clog2(NEED_W + 1);

   localparam logic [NUM_CLASSES-1:0] HEAD_VALID_RST =
      (ARENA_LOG < NUM_CLASSES) ? (NUM_CLASSES'(1) << ARENA_LOG) : '0;
   localparam logic [TAG_W-1:0] TAG0_RST =
      (ARENA_LOG < NUM_CLASSES) ? TAG_W'(ARENA_LOG) : '0;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_CLASS = 10'b00_0000_0010,
      S_FIND  = 10'b00_0000_0100,
      S_POP   = 10'b00_0000_1000,
      S_LINK  = 10'b00_0001_0000,
      S_SPLIT = 10'b00_0010_0000,
      S_TAG   = 10'b00_0100_0000,
      S_FREAD = 10'b00_1000_0000,
      S_FPUSH = 10'b01_0000_0000,
      S_RESP  = 10'b10_0000_0000
   } state_type;

   // number of bits needed to hold v: ceil(log2(v + 1))
   function automatic logic [LEN_W-1:0] bit_length(input logic [NEED_W-1:0] v);
      logic [LEN_W-1:0] len;
      len = '0;
      for (int i = 0; i < NEED_W; i++) begin
         if (v[i]) begin
            len = LEN_W'(i + 1);
         end
      end
      return len;
   endfunction

   // lowest non-empty class at or above cls, with a found flag on top
   function automatic logic [CLS_W:0] find_class(input logic [NUM_CLASSES-1:0] valid,
                                                 input logic [CLS_W-1:0]       cls);
      logic [CLS_W:0] res;
      res = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (valid[i] && (i >= int'(cls))) begin
            res = {1'b1, CLS_W'(i)};
         end
      end
      return res;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [AW-1:0] a);
      return a[AW-1:SLOT_LOG];
   endfunction

   // control state
   state_type               state_ff, state_in;
   logic [NUM_CLASSES-1:0]  head_valid_ff, head_valid_in;
   logic [AW-1:0]           head_addr_ff [NUM_CLASSES];
   logic [AW-1:0]           head_addr_in [NUM_CLASSES];
   logic [SPLITS_W-1:0]     split_cnt_ff, split_cnt_in;
   logic                    link0_wr_ff, link0_wr_in;
   logic                    tag0_wr_ff, tag0_wr_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   action_type              action_ff, action_in;
   logic                    req_zero_ff, req_zero_in;
   logic [NEED_W-1:0]       need_m1_ff, need_m1_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [CLS_W-1:0]        cls_ff, cls_in;
   logic [CLS_W-1:0]        cur_ff, cur_in;
   logic                    fail_ff, fail_in;

   // response payload
   status_type              rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0]     rsp_offset_ff, rsp_offset_in;
   logic [BLOCK_BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [SPLITS_W-1:0]     rsp_splits_ff, rsp_splits_in;

   // memory ports
   logic                    link_we;
   logic [SLOT_W-1:0]       link_waddr;
   logic [LINK_W-1:0]       link_wdata;
   logic [SLOT_W-1:0]       link_raddr;
   logic [LINK_W-1:0]       link_rd;
   logic                    tag_we;
   logic [SLOT_W-1:0]       tag_waddr;
   logic [TAG_W-1:0]        tag_wdata;
   logic [TAG_W-1:0]        tag_rd;

   // datapath helpers
   logic                    req_xfer;
   logic                    rsp_load;
   logic [AW-1:0]           rel_base;
   logic [AW-1:0]           free_addr;
   logic [CLS_W-1:0]        cur_dn;
   logic [AW-1:0]           push_addr;
   logic [CLS_W-1:0]        head_idx;
   logic [AW-1:0]           head_rd;
   logic                    head_vrd;
   logic [LINK_W-1:0]       link_q;
   logic [TAG_W-1:0]        tag_q;
   logic                    tag_ok;
   logic [CLS_W-1:0]        tag_idx;
   logic [LEN_W-1:0]        cls_raw;
   logic [CLS_W:0]          find_res;
   logic                    alloc_ok;

   assign req_xfer = req_chan.valid && req_chan.ready;

   // free: user pointer back to block start, wrapped and slot aligned
   assign rel_base  = AW'(32'(req_chan.release_offset) - 32'(HEADER_BYTES));
   assign free_addr = {rel_base[AW-1:SLOT_LOG], {SLOT_LOG{1'b0}}};

   // halving: upper half of the current block at the next class down
   assign cur_dn    = cur_ff - CLS_W'(1);
   assign push_addr = AW'(32'(addr_ff) + (32'd1 << cur_dn));

   assign cls_raw  = bit_length(need_m1_ff);
   assign find_res = find_class(head_valid_ff, cls_ff);

   // slot 0 holds its reset contents until first written
   assign link_q  = ((slot_of(addr_ff) == '0) && !link0_wr_ff) ? '0 : link_rd;
   assign tag_q   = ((slot_of(addr_ff) == '0) && !tag0_wr_ff) ? TAG0_RST : tag_rd;
   assign tag_ok  = int'(tag_q) < NUM_CLASSES;
   assign tag_idx = tag_q[CLS_W-1:0];

   // one head lookup per cycle, steered by the sequencer
   always_comb begin
      unique case (state_ff)
         S_SPLIT: head_idx = cur_dn;
         S_FPUSH: head_idx = tag_idx;
         default: head_idx = cur_ff;
      endcase
   end

   assign head_rd  = head_addr_ff[head_idx];
   assign head_vrd = head_valid_ff[head_idx];

   // memory access: link words are written on every push, read on every pop
   assign link_raddr = slot_of(head_rd);
   assign link_we    = (state_ff == S_SPLIT) || ((state_ff == S_FPUSH) && tag_ok);
   assign link_waddr = (state_ff == S_SPLIT) ? slot_of(push_addr) : slot_of(addr_ff);
   assign link_wdata = {head_vrd, head_rd};

   assign tag_we    = (state_ff == S_SPLIT) || (state_ff == S_TAG);
   assign tag_waddr = (state_ff == S_SPLIT) ? slot_of(push_addr) : slot_of(addr_ff);
   assign tag_wdata = (state_ff == S_SPLIT) ? TAG_W'(cur_dn) : TAG_W'(cls_ff);

   // response payload built from the finished item
   assign alloc_ok = (action_ff == ACT_ALLOC) && !fail_ff;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_status_in = fail_ff ? STAT_FAIL : STAT_DONE;
      rsp_offset_in = alloc_ok ? OFFSET_W'(32'(addr_ff) + 32'(HEADER_BYTES)) : '0;
      rsp_bytes_in  = alloc_ok ? (BLOCK_BYTES_W'(1) << cls_ff) : '0;
      rsp_splits_in = split_cnt_ff;
   end

   // hold a response until its transfer, load a new one when the slot frees
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_valid_in = head_valid_ff;
      head_addr_in  = head_addr_ff;
      split_cnt_in  = split_cnt_ff;
      action_in     = action_ff;
      req_zero_in   = req_zero_ff;
      need_m1_in    = need_m1_ff;
      addr_in       = addr_ff;
      cls_in        = cls_ff;
      cur_in        = cur_ff;
      fail_in       = fail_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               action_in   = req_chan.action;
               req_zero_in = (req_chan.request_bytes == '0);
               need_m1_in  = NEED_W'(req_chan.request_bytes) + NEED_W'(HEADER_BYTES)
                             - NEED_W'(1);
               addr_in     = free_addr;
               fail_in     = 1'b0;
               if (req_chan.action == ACT_FREE) begin
                  if (req_chan.release_present) begin
                     state_in = S_FREAD;
                  end else begin
                     fail_in  = 1'b1;
                     state_in = S_RESP;
                  end
               end else begin
                  state_in = S_CLASS;
               end
            end
         end
         S_CLASS: begin
            // rounded class, reject zero and oversized requests
            if (req_zero_ff || (int'(cls_raw) >= NUM_CLASSES)) begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               cls_in   = cls_raw[CLS_W-1:0];
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (find_res[CLS_W]) begin
               cur_in   = find_res[CLS_W-1:0];
               state_in = S_POP;
            end else begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end
         end
         S_POP: begin
            // link read of the head slot is in flight
            addr_in  = head_rd;
            state_in = S_LINK;
         end
         S_LINK: begin
            head_addr_in[cur_ff]  = link_q[AW] ? link_q[AW-1:0] : '0;
            head_valid_in[cur_ff] = link_q[AW];
            state_in = (cur_ff != cls_ff) ? S_SPLIT : S_TAG;
         end
         S_SPLIT: begin
            // push the upper half onto the next class down
            head_addr_in[cur_dn]  = push_addr;
            head_valid_in[cur_dn] = 1'b1;
            split_cnt_in          = split_cnt_ff + SPLITS_W'(1);
            cur_in                = cur_dn;
            if (cur_dn == cls_ff) begin
               state_in = S_TAG;
            end
         end
         S_TAG: begin
            state_in = S_RESP;
         end
         S_FREAD: begin
            // class tag read of the freed slot is in flight
            state_in = S_FPUSH;
         end
         S_FPUSH: begin
            if (tag_ok) begin
               head_addr_in[tag_idx]  = addr_ff;
               head_valid_in[tag_idx] = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign link0_wr_in = link0_wr_ff || (link_we && (link_waddr == '0));
   assign tag0_wr_in  = tag0_wr_ff || (tag_we && (tag_waddr == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_valid_ff <= HEAD_VALID_RST;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_addr_ff[i] <= '0;
         end
         split_cnt_ff  <= '0;
         link0_wr_ff   <= 1'b0;
         tag0_wr_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         head_addr_ff  <= head_addr_in;
         split_cnt_ff  <= split_cnt_in;
         link0_wr_ff   <= link0_wr_in;
         tag0_wr_ff    <= tag0_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      req_zero_ff <= req_zero_in;
      need_m1_ff  <= need_m1_in;
      addr_ff     <= addr_in;
      cls_ff      <= cls_in;
      cur_ff      <= cur_in;
      fail_ff     <= fail_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_splits_ff <= rsp_splits_in;
      end
   end

   // next-link words: previous head address of the list pushed onto plus a valid bit
   p2alloc_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOT_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   // class tag of the block starting at each slot
   p2alloc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (SLOT_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_addr (slot_of(addr_ff)),
      .rd_data (tag_rd)
   );

   // request side is open only between items
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.user_offset  = rsp_offset_ff;
   assign rsp_chan.block_bytes  = rsp_bytes_ff;
   assign rsp_chan.splits_total = rsp_splits_ff;

   // list heads never move while waiting for a request
   `P2A_ASSERT_NXT(a_idle_heads_hold, clock, reset, state_ff == S_IDLE, $stable(head_valid_ff), "head valid bits changed after idle")

   // the halving count moves only on a halving step
   `P2A_ASSERT_NXT(a_splits_only_split, clock, reset, state_ff != S_SPLIT, $stable(split_cnt_ff), "split count moved outside a halving")

   // a halving step always starts above the target class
   `P2A_ASSERT_IMP(a_split_above_class, clock, reset, state_ff == S_SPLIT, cur_ff > cls_ff, "halving at or below the target class")

   // link words are written by pushes only
   `P2A_ASSERT_IMP(a_link_write_push, clock, reset, link_we, (state_ff == S_SPLIT) || (state_ff == S_FPUSH), "link write outside a push")

   // a failed or ignored item carries no block
   `P2A_ASSERT_IMP(a_fail_empty_payload, clock, reset, rsp_valid_ff && (rsp_status_ff == STAT_FAIL), (rsp_offset_ff == '0) && (rsp_bytes_ff == '0), "failure response with block data")

endmodule
